### design/md5_pkg.sv
// Package with MD5 constants, shared types and round helper functions.
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } cmd_t;

    function automatic logic [31:0] step_const(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [7:0] g;
        begin
            case (i[5:4])
                2'd0: g = {2'b00, i};
                2'd1: g = 8'(5 * i + 1);
                2'd2: g = 8'(3 * i + 5);
                default: g = 8'(7 * i);
            endcase
            return g[3:0];
        end
    endfunction

endpackage

### design/md5_front.sv
// Front end: input register queue that decouples the input channel from the core.
module md5_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  md5_pkg::cmd_t   in_cmd,
    output logic            q_valid,
    input  logic            q_pop,
    output md5_pkg::cmd_t   q_cmd
);

    md5_pkg::cmd_t                    mem_reg [md5_pkg::QUEUE_DEPTH];
    logic [md5_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [md5_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [md5_pkg::QUEUE_AW:0]       count_reg, count_next;
    logic                             push;
    logic                             pop;
    logic                             useful;

    // Items that carry neither a byte nor a finish request are dropped here.
    assign useful   = in_cmd.present | in_cmd.last;
    assign in_stall = (count_reg == (md5_pkg::QUEUE_AW+1)'(md5_pkg::QUEUE_DEPTH));
    assign push     = in_valid & ~in_stall & useful;
    assign pop      = q_pop & q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (md5_pkg::QUEUE_AW+1)'(push)
                      - (md5_pkg::QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (md5_pkg::QUEUE_AW+1)'(md5_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid == (count_reg != '0))
        else $error("queue valid mismatch");

endmodule

### design/md5_core.sv
// Back end: byte packing, padding sequencer, one MD5 step per cycle and digest output.
module md5_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  md5_pkg::cmd_t   q_cmd,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     out_a,
    output logic [31:0]     out_b,
    output logic [31:0]     out_c,
    output logic [31:0]     out_d
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PUSH  = 6'b000010,
        ST_PAD   = 6'b000100,
        ST_LEN   = 6'b001000,
        ST_COMP  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    logic [31:0]    m_reg [16];
    logic [31:0]    h_reg [4];
    logic [31:0]    a_reg, b_reg, c_reg, d_reg;
    logic [63:0]    count_reg;
    logic [63:0]    len_reg;
    logic [5:0]     step_reg;
    logic [2:0]     lenidx_reg;
    logic           finish_reg;
    logic           out_valid_reg;
    logic [31:0]    out_reg [4];
    logic [5:0]     pos;
    logic           wr_en;
    logic [7:0]     wr_byte;
    logic [31:0]    f;
    logic [31:0]    t;
    logic [31:0]    rot;
    logic [4:0]     s;
    logic           load_out;

    assign pos      = count_reg[8:3];
    assign s        = md5_pkg::rot_amount(step_reg);
    assign load_out = (state_reg == ST_DONE) && (state_next == ST_IDLE);

    always_comb
    begin
        unique case (step_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t   = a_reg + f + m_reg[md5_pkg::msg_index(step_reg)] + md5_pkg::step_const(step_reg);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = 8'h00;
        unique case (state_reg)
            ST_PUSH:
            begin
                wr_en   = 1'b1;
                wr_byte = 8'h80;
            end
            ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_byte = 8'h00;
            end
            ST_LEN:
            begin
                wr_en   = 1'b1;
                wr_byte = len_reg[8*lenidx_reg +: 8];
            end
            ST_IDLE:
            begin
                wr_en   = q_valid & q_cmd.present;
                wr_byte = q_cmd.data;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.present && pos == 6'd63)
                    begin
                        state_next = ST_COMP;
                        ret_next   = q_cmd.last ? ST_PUSH : ST_IDLE;
                    end
                    else if (q_cmd.last)
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH, ST_PAD:
            begin
                if (pos == 6'd63)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_PAD;
                end
                else if (pos == 6'd55)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_LEN:
            begin
                if (lenidx_reg == 3'd7)
                begin
                    state_next = ST_COMP;
                    ret_next   = ST_DONE;
                end
            end
            ST_COMP:
            begin
                if (step_reg == 6'd63)
                begin
                    state_next = ret_reg;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            lenidx_reg    <= '0;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            h_reg[0]      <= md5_pkg::INIT_A;
            h_reg[1]      <= md5_pkg::INIT_B;
            h_reg[2]      <= md5_pkg::INIT_C;
            h_reg[3]      <= md5_pkg::INIT_D;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (out_valid_reg && !out_stall && !load_out)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                count_reg <= count_reg + 64'd8;
            end
            if (state_reg == ST_IDLE && q_valid)
            begin
                finish_reg <= q_cmd.last;
            end
            if (state_reg == ST_LEN)
            begin
                lenidx_reg <= lenidx_reg + 1'b1;
            end
            else
            begin
                lenidx_reg <= '0;
            end
            if (state_reg == ST_COMP)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 6'd63)
                begin
                    h_reg[0] <= h_reg[0] + d_reg;
                    h_reg[1] <= h_reg[1] + b_reg + rot;
                    h_reg[2] <= h_reg[2] + b_reg;
                    h_reg[3] <= h_reg[3] + c_reg;
                end
            end
            else
            begin
                step_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                h_reg[0]      <= md5_pkg::INIT_A;
                h_reg[1]      <= md5_pkg::INIT_B;
                h_reg[2]      <= md5_pkg::INIT_C;
                h_reg[3]      <= md5_pkg::INIT_D;
                count_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            m_reg[pos[5:2]][8*pos[1:0] +: 8] <= wr_byte;
        end
        if (state_reg == ST_PUSH)
        begin
            len_reg <= count_reg;
        end
        if (state_reg != ST_COMP)
        begin
            a_reg <= (state_next == ST_COMP) ? h_reg[0] : a_reg;
            b_reg <= (state_next == ST_COMP) ? h_reg[1] : b_reg;
            c_reg <= (state_next == ST_COMP) ? h_reg[2] : c_reg;
            d_reg <= (state_next == ST_COMP) ? h_reg[3] : d_reg;
        end
        else
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
        if (load_out)
        begin
            out_reg[0] <= h_reg[0];
            out_reg[1] <= h_reg[1];
            out_reg[2] <= h_reg[2];
            out_reg[3] <= h_reg[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_a     = out_reg[0];
    assign out_b     = out_reg[1];
    assign out_c     = out_reg[2];
    assign out_d     = out_reg[3];

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && step_reg != 6'd63) |=> state_reg == ST_COMP)
        else $error("compression left early");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN) |-> pos[5:3] == 3'd7)
        else $error("length written at wrong position");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_reg[0]))
        else $error("stalled digest lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> finish_reg)
        else $error("digest without finish request");

endmodule

### design/md5_message_digest.sv
// Top level of the MD5 engine: input queue feeding the compression core.
//
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | message_byte, byte_present, end_of_message
//  out     | output    | out_valid/stall | digest_word_a .. digest_word_d
//
// Bytes are taken one per cycle while the core is idle; the 64th byte of a block
// starts a compression, one MD5 step per cycle in the single round unit of the core.
// A finish walks the padding one byte per cycle (9 to 72 bytes plus one or two
// compressions) and then loads the digest into the output register.
// Reset is asynchronous and loads the standard initial chaining words.
// The two-entry input queue keeps taking items, until it is full, while the core
// works or the digest transfer is stalled.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word_a,
    output logic [31:0] digest_word_b,
    output logic [31:0] digest_word_c,
    output logic [31:0] digest_word_d
);

    md5_pkg::cmd_t  in_cmd;
    md5_pkg::cmd_t  q_cmd;
    logic           q_valid;
    logic           q_pop;

    assign in_cmd.data    = message_byte;
    assign in_cmd.present = byte_present;
    assign in_cmd.last    = end_of_message;

    md5_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    md5_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_a     (digest_word_a),
        .out_b     (digest_word_b),
        .out_c     (digest_word_c),
        .out_d     (digest_word_d)
    );

endmodule
